// ===== rtl/spq_pkg.sv =====
// shared types and codes for the sorted priority queue
package spq_pkg;

   // requested action codes
   localparam logic [1:0] ACTION_INSERT = 2'd0;
   localparam logic [1:0] ACTION_REMOVE = 2'd1;
   localparam logic [1:0] ACTION_FIND   = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   // request payload
   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] item_value;
   } req_type;

   // result payload
   typedef struct packed {
      logic [1:0]         status;
      logic [3:0]         match_position;
      logic signed [31:0] smallest_value;
      logic               queue_empty;
      logic [4:0]         entry_count;
   } rsp_type;

   // command broadcast to every cell of the chain
   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_COMPARE,
      CMD_INSERT,
      CMD_REMOVE
   } cell_cmd_type;

   // compare flags kept by each cell
   typedef struct packed {
      logic lt;
      logic eq;
   } cell_flags_type;

endpackage

// ===== rtl/spq_cell.sv =====
// one storage cell of the sorted chain: compare, shift up, shift down
module spq_cell #(
   parameter int VALUE_BITS = 32,
   parameter int COUNT_BITS = 5,
   parameter int INDEX      = 0
) (
   input  logic                         clock,
   input  spq_pkg::cell_cmd_type        cmd,
   input  logic [COUNT_BITS-1:0]        count,
   input  logic signed [VALUE_BITS-1:0] value,
   input  logic                         left_lt,
   input  logic signed [VALUE_BITS-1:0] left_entry,
   input  logic signed [VALUE_BITS-1:0] right_entry,
   output logic signed [VALUE_BITS-1:0] entry,
   output spq_pkg::cell_flags_type      flags
);

   logic signed [VALUE_BITS-1:0] entry_ff;
   logic signed [VALUE_BITS-1:0] entry_in;
   spq_pkg::cell_flags_type      flags_ff;
   spq_pkg::cell_flags_type      flags_in;
   logic                         occupied;

   // the cell holds a live entry when its position is below the count
   assign occupied = count > COUNT_BITS'(INDEX);

   // next entry and flags
   always_comb begin
      entry_in = entry_ff;
      flags_in = flags_ff;
      unique case (cmd)
         spq_pkg::CMD_HOLD: begin
         end
         spq_pkg::CMD_COMPARE: begin
            flags_in.lt = occupied && (entry_ff < value);
            flags_in.eq = occupied && (entry_ff == value);
         end
         spq_pkg::CMD_INSERT: begin
            // cells at or past the insert point move up by one
            if (!flags_ff.lt) begin
               entry_in = left_lt ? value : left_entry;
            end
         end
         spq_pkg::CMD_REMOVE: begin
            // cells at or past the removed entry take their right neighbor
            if (!flags_ff.lt) begin
               entry_in = right_entry;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      flags_ff <= flags_in;
   end

   assign entry = entry_ff;
   assign flags = flags_ff;

endmodule

// ===== rtl/sorted_priority_queue_unit.sv =====
// sorted priority queue built as a chain of compare-and-shift cells
//
//  channel   ports                          direction  handshake
//  request   start, busy, req_item          in         taken when start and not busy
//  result    rsp_strobe, rsp_item           out        one cycle, strobe marks it
//
// a request runs through the compare, update and report states before the next one is accepted:
// the cells compare and register flags, then shift, then the result is
// registered and shown with rsp_strobe while the unit is already free again
// the rate is set by the registered per-cell flags and the position encode
// reset clears the entry count and the controller; entries need no clearing
// the receiver cannot stall, so each result is shown for exactly one cycle
module sorted_priority_queue_unit #(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  spq_pkg::req_type req_item,
   output logic             rsp_strobe,
   output spq_pkg::rsp_type rsp_item
);

   localparam int POS_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_UPDATE,
      ST_REPORT
   } state_type;

   state_type                    state_ff;
   logic [COUNT_BITS-1:0]        count_ff;
   logic [1:0]                   action_ff;
   logic signed [VALUE_BITS-1:0] value_ff;
   spq_pkg::rsp_type             rsp_ff;
   logic                         strobe_ff;

   logic signed [VALUE_BITS-1:0] entries [CAPACITY];
   spq_pkg::cell_flags_type      flags [CAPACITY];
   logic [CAPACITY-1:0]          lt_vec;
   logic [CAPACITY-1:0]          eq_vec;
   logic [CAPACITY-1:0]          boundary;
   logic [POS_BITS-1:0]          pos_enc;
   logic                         hit;

   spq_pkg::cell_cmd_type        cmd;
   logic [1:0]                   status_calc;
   logic [POS_BITS-1:0]          pos_calc;
   logic [COUNT_BITS-1:0]        count_next;
   spq_pkg::cell_cmd_type        update_cmd;

   // chain of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                         left_lt;
      logic signed [VALUE_BITS-1:0] left_entry;
      logic signed [VALUE_BITS-1:0] right_entry;

      if (i == 0) begin : g_head
         assign left_lt    = 1'b1;
         assign left_entry = entries[i];
      end else begin : g_mid
         assign left_lt    = flags[i-1].lt;
         assign left_entry = entries[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_entry = entries[i];
      end else begin : g_body
         assign right_entry = entries[i+1];
      end

      spq_cell #(
         .VALUE_BITS (VALUE_BITS),
         .COUNT_BITS (COUNT_BITS),
         .INDEX      (i)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .count       (count_ff),
         .value       (value_ff),
         .left_lt     (left_lt),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (entries[i]),
         .flags       (flags[i])
      );

      assign lt_vec[i] = flags[i].lt;
      assign eq_vec[i] = flags[i].eq;
   end

   // first cell that is not below the value, and its position
   always_comb begin
      boundary    = '0;
      pos_enc     = '0;
      boundary[0] = ~lt_vec[0];
      for (int i = 1; i < CAPACITY; i++) begin
         boundary[i] = lt_vec[i-1] & ~lt_vec[i];
      end
      for (int i = 0; i < CAPACITY; i++) begin
         if (boundary[i]) begin
            pos_enc = pos_enc | POS_BITS'(i);
         end
      end
   end

   assign hit = |(boundary & eq_vec);

   // decision for the shift cycle
   always_comb begin
      status_calc = spq_pkg::STATUS_DONE;
      pos_calc    = '0;
      count_next  = count_ff;
      update_cmd  = spq_pkg::CMD_HOLD;
      priority if (action_ff == spq_pkg::ACTION_INSERT) begin
         if (count_ff == COUNT_BITS'(CAPACITY)) begin
            status_calc = spq_pkg::STATUS_FULL;
         end else begin
            pos_calc   = pos_enc;
            count_next = count_ff + 1'b1;
            update_cmd = spq_pkg::CMD_INSERT;
         end
      end else if (!hit) begin
         status_calc = spq_pkg::STATUS_NOT_FOUND;
      end else if (action_ff == spq_pkg::ACTION_REMOVE) begin
         pos_calc   = pos_enc;
         count_next = count_ff - 1'b1;
         update_cmd = spq_pkg::CMD_REMOVE;
      end else begin
         pos_calc = pos_enc;
      end
   end

   // command broadcast to the cells
   always_comb begin
      unique case (state_ff)
         ST_COMPARE: cmd = spq_pkg::CMD_COMPARE;
         ST_UPDATE:  cmd = update_cmd;
         default:    cmd = spq_pkg::CMD_HOLD;
      endcase
   end

   // controller, count and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  action_ff <= req_item.action;
                  value_ff  <= VALUE_BITS'(req_item.item_value);
                  state_ff  <= ST_COMPARE;
               end
            end
            ST_COMPARE: begin
               state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               rsp_ff.status         <= status_calc;
               rsp_ff.match_position <= 4'(pos_calc);
               count_ff              <= count_next;
               state_ff              <= ST_REPORT;
            end
            ST_REPORT: begin
               rsp_ff.smallest_value <= (count_ff != '0) ? 32'(entries[0]) : '0;
               rsp_ff.queue_empty    <= (count_ff == '0);
               rsp_ff.entry_count    <= 5'(count_ff);
               strobe_ff             <= 1'b1;
               state_ff              <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(CAPACITY))
      else $error("entry count above capacity");

   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   a_boundary_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> $onehot0(boundary))
      else $error("more than one insert point in the chain");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but unit not busy");

endmodule
